@@ sv/pps_pkg.sv @@
package pps_pkg;

  // Row length and working value width
  localparam int unsigned NUM_STAGES = 64;
  localparam int unsigned VALUE_BITS = 16;

  // Fixed width of the candidate and prime value ports
  localparam int unsigned FIELD_BITS = 16;

  // Bit counter of the serializer
  localparam int unsigned CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  // One beat of the bit stream that travels down the row of cells.
  // alive and placed are meaningful on the last beat of a word.
  typedef struct packed {
    logic vld;
    logic dbit;
    logic first;
    logic last;
    logic alive;
    logic placed;
  } lane_t;

endpackage

@@ sv/pipelined_prime_sieve_core.sv @@
// Prime sieve built as a row of identical cells, one cell per stored base.
// A candidate word is shifted out MSB first and its bits ripple down the row,
// one cell per cycle; every filled cell folds each bit into its own remainder
// against its base, so the row computes all remainders in a wavefront. The
// last bit carries the verdict: a cell whose base divides the word kills it,
// and the first empty cell that still sees it alive stores it as a new base.
// Exactly one result word comes back per candidate: prime (value and
// is_prime), overflow (survived a full row) or all zeros (dropped). A set
// clear empties the row before that candidate is tested. One candidate is in
// the row at a time; after acceptance a word is shifted out bit by bit and
// its result is ready once its last bit has left the final cell of the row.
// A finished result waits in a holding register until the output register
// is free or being taken; the next candidate is taken once it has moved on,
// even while the output side still stalls on that result.
module pipelined_prime_sieve_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pps_pkg::FIELD_BITS-1:0]  candidate_i,
  input  logic                            clear_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pps_pkg::FIELD_BITS-1:0]  prime_value_o,
  output logic                            is_prime_o,
  output logic                            overflow_o
);

  logic                               in_acc;
  logic                               row_clr;
  logic [pps_pkg::VALUE_BITS-1:0]     value;

  // lane[0] comes from the serializer, lane[k+1] leaves cell k
  pps_pkg::lane_t                     lane [pps_pkg::NUM_STAGES+1];
  pps_pkg::lane_t                     tail;
  logic                               done;

  // busy covers one candidate from acceptance until its result leaves
  // the holding register
  logic                               busy_q, busy_d;
  logic                               hold_vld_q, hold_vld_d;
  logic                               hold_prime_q, hold_prime_d;
  logic                               hold_ovf_q, hold_ovf_d;
  logic [pps_pkg::FIELD_BITS-1:0]     hold_val_q, hold_val_d;

  logic                               out_vld_q, out_vld_d;
  logic                               out_prime_q, out_prime_d;
  logic                               out_ovf_q, out_ovf_d;
  logic [pps_pkg::FIELD_BITS-1:0]     out_val_q, out_val_d;

  logic                               move;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign row_clr    = in_acc && clear_i;

  pps_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .value_i (pps_pkg::VALUE_BITS'(candidate_i)),
    .value_o (value),
    .lane_o  (lane[0])
  );

  for (genvar k = 0; k < pps_pkg::NUM_STAGES; k++) begin : g_cell
    pps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (row_clr),
      .value_i (value),
      .lane_i  (lane[k]),
      .lane_o  (lane[k+1])
    );
  end

  // the last beat leaving the final cell closes the candidate
  assign tail = lane[pps_pkg::NUM_STAGES];
  assign done = tail.vld && tail.last;

  // advance the held result when the output register is free or being taken
  assign move = hold_vld_q && (!out_vld_q || !out_stall_i);

  always_comb begin
    busy_d       = busy_q;
    hold_vld_d   = hold_vld_q;
    hold_prime_d = hold_prime_q;
    hold_ovf_d   = hold_ovf_q;
    hold_val_d   = hold_val_q;
    if (in_acc) begin
      busy_d = 1'b1;
    end else if (move) begin
      busy_d = 1'b0;
    end
    if (done) begin
      hold_vld_d   = 1'b1;
      hold_prime_d = tail.placed;
      hold_ovf_d   = tail.alive;
      hold_val_d   = tail.placed ? pps_pkg::FIELD_BITS'(value) : '0;
    end else if (move) begin
      hold_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d   = out_vld_q;
    out_prime_d = out_prime_q;
    out_ovf_d   = out_ovf_q;
    out_val_d   = out_val_q;
    if (move) begin
      out_vld_d   = 1'b1;
      out_prime_d = hold_prime_q;
      out_ovf_d   = hold_ovf_q;
      out_val_d   = hold_val_q;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign prime_value_o = out_val_q;
  assign is_prime_o    = out_prime_q;
  assign overflow_o    = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_prime_q <= hold_prime_d;
    hold_ovf_q   <= hold_ovf_d;
    hold_val_q   <= hold_val_d;
    out_prime_q  <= out_prime_d;
    out_ovf_q    <= out_ovf_d;
    out_val_q    <= out_val_d;
  end

endmodule

@@ sv/pps_serializer.sv @@
module pps_serializer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pps_pkg::VALUE_BITS-1:0]      value_i,
  output logic [pps_pkg::VALUE_BITS-1:0]      value_o,
  output pps_pkg::lane_t                      lane_o
);

  logic                               run_q, run_d;
  logic [pps_pkg::CNT_BITS-1:0]       cnt_q, cnt_d;
  logic [pps_pkg::VALUE_BITS-1:0]     sh_q, sh_d;
  logic [pps_pkg::VALUE_BITS-1:0]     val_q, val_d;
  logic                               last_beat;

  assign last_beat = (cnt_q == pps_pkg::CNT_BITS'(pps_pkg::VALUE_BITS - 1));

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    sh_d  = sh_q;
    val_d = val_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      sh_d  = value_i;
      val_d = value_i;
    end else if (run_q) begin
      // shift out MSB first, stop after the last bit
      sh_d  = sh_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (last_beat) begin
        run_d = 1'b0;
      end
    end
  end

  always_comb begin
    lane_o.vld    = run_q;
    lane_o.dbit   = sh_q[pps_pkg::VALUE_BITS-1];
    lane_o.first  = (cnt_q == '0);
    lane_o.last   = last_beat;
    lane_o.alive  = 1'b1;
    lane_o.placed = 1'b0;
  end

  assign value_o = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    val_q <= val_d;
  end

endmodule

@@ sv/pps_cell.sv @@
module pps_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clr_i,
  input  logic [pps_pkg::VALUE_BITS-1:0]  value_i,
  input  pps_pkg::lane_t                  lane_i,
  output pps_pkg::lane_t                  lane_o
);

  logic                               used_q, used_d;
  logic [pps_pkg::VALUE_BITS-1:0]     base_q, base_d;
  logic [pps_pkg::VALUE_BITS-1:0]     rem_q, rem_d;
  pps_pkg::lane_t                     lane_q, lane_d;

  logic [pps_pkg::VALUE_BITS:0]       rem_shift;
  logic [pps_pkg::VALUE_BITS:0]       diff;
  logic [pps_pkg::VALUE_BITS-1:0]     rem_nxt;
  logic                               ge;
  logic                               divides;

  // one restoring remainder step per incoming bit
  always_comb begin
    if (lane_i.first) begin
      rem_shift = (pps_pkg::VALUE_BITS + 1)'(lane_i.dbit);
    end else begin
      rem_shift = {rem_q, lane_i.dbit};
    end
    diff    = rem_shift - {1'b0, base_q};
    ge      = (rem_shift >= {1'b0, base_q});
    rem_nxt = ge ? diff[pps_pkg::VALUE_BITS-1:0] : rem_shift[pps_pkg::VALUE_BITS-1:0];
    divides = (rem_nxt == '0);
  end

  always_comb begin
    used_d = used_q;
    base_d = base_q;
    rem_d  = rem_q;
    lane_d = lane_i;
    if (clr_i) begin
      used_d = 1'b0;
    end else if (lane_i.vld) begin
      rem_d = rem_nxt;
      if (lane_i.last && lane_i.alive) begin
        if (used_q) begin
          // drop the word when the base divides it
          if (divides) begin
            lane_d.alive = 1'b0;
          end
        end else begin
          // first empty cell takes the survivor as its base
          used_d        = 1'b1;
          base_d        = value_i;
          lane_d.alive  = 1'b0;
          lane_d.placed = 1'b1;
        end
      end
    end
  end

  assign lane_o = lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      lane_q <= '0;
    end else begin
      used_q <= used_d;
      lane_q <= lane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rem_q  <= rem_d;
  end

endmodule
